// File: rtl/lfid_pkg.sv
// ----------------------------------------------------------------------------
// Lowest-free ID allocator package
// Payload types, register indexes and fixed widths shared by the allocator
// files.
// ----------------------------------------------------------------------------
package lfid_pkg;

    localparam int ID_BITS      = 10;
    localparam int WORD_BITS    = 32;
    localparam int BIT_IDX_BITS = 5;
    localparam int CFG_IDX_BITS = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LOW  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_HIGH = 4'd1;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [ID_BITS-1:0] release_id;
    } t_in_item;

    typedef struct packed {
        logic               granted;
        logic [ID_BITS-1:0] granted_id;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0] reg_index;
        logic [ID_BITS-1:0]      reg_data;
    } t_cfg_item;

    typedef struct packed {
        logic                    found;
        logic [BIT_IDX_BITS-1:0] idx;
    } t_enc_res;

endpackage

// File: rtl/lfid_chan_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// One beat moves a payload when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface lfid_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/lfid_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/lfid_prio_enc.sv
// ----------------------------------------------------------------------------
// Lowest-set-bit encoder
// Finds the lowest set bit of one bitmap word; shared between the summary
// search and the word search.
// ----------------------------------------------------------------------------
module lfid_prio_enc (
    input  logic [lfid_pkg::WORD_BITS-1:0] i_vec,
    output lfid_pkg::t_enc_res             o_res
);

    always_comb begin
        o_res.found = |i_vec;
        o_res.idx   = '0;
        for (int k = lfid_pkg::WORD_BITS - 1; k >= 0; k--) begin
            if (i_vec[k]) begin
                o_res.idx = lfid_pkg::BIT_IDX_BITS'(k);
            end
        end
    end

endmodule

// File: rtl/lowest_free_id_allocator_core.sv
// ----------------------------------------------------------------------------
// Lowest-free ID allocator
// Hands out IDs from a configured range, reusing the lowest released ID first.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries requests: action 0 allocates, action 1 releases release_id.
//   o_out carries one beat per allocate: granted and granted_id (zero on fail).
//   Releases produce no beat. i_cfg writes range_low (index 0) and range_high
//   (index 1); a write to either resets the bump pointer and empties the free bitmap.
// Timing:
//   The free bitmap lives in a RAM of 32-bit words plus a per-word summary
//   register. One lowest-set-bit encoder is used first on the summary, then
//   on the selected word. A bitmap allocate reads the word, then writes it
//   back with the bit cleared; a bump-pointer allocate skips the RAM; an
//   in-range release reads, then writes back; an ignored release stays idle.
//   Throughput is set by the RAM's read-modify-write and the single encoder.
// Reset and stalls:
//   Reset restores the full range, sets the pointer to 0 and clears the
//   summary, so no clearing pass is needed. A result waits in the output
//   register; the block keeps taking requests meanwhile, holds the next
//   allocate result until the register is free and takes none while it does.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_core #(
    parameter int ID_COUNT = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lfid_chan_if.sink      i_in,
    lfid_chan_if.source    o_out,
    lfid_chan_if.sink      i_cfg
);

    localparam int ID_SPAN    = 1 << lfid_pkg::ID_BITS;
    localparam int USED_COUNT = (ID_COUNT < ID_SPAN) ? ID_COUNT : ID_SPAN;
    localparam int WORDS      = (USED_COUNT + lfid_pkg::WORD_BITS - 1) / lfid_pkg::WORD_BITS;
    localparam int WA_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [lfid_pkg::ID_BITS-1:0] MAX_ID = lfid_pkg::ID_BITS'(USED_COUNT - 1);
    localparam int RID_WORD_W = lfid_pkg::ID_BITS - lfid_pkg::BIT_IDX_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_REL   = 2'd1;
    localparam logic [1:0] ST_ALLOC = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]                      r_state, n_state;
    logic [lfid_pkg::ID_BITS-1:0]    r_range_low, n_range_low;
    logic [lfid_pkg::ID_BITS-1:0]    r_range_high, n_range_high;
    logic [lfid_pkg::ID_BITS-1:0]    r_eff_lo, n_eff_lo;
    logic [lfid_pkg::ID_BITS-1:0]    r_eff_hi, n_eff_hi;
    logic [lfid_pkg::ID_BITS:0]      r_ptr, n_ptr;
    logic [WORDS-1:0]                r_summary, n_summary;
    logic [WA_W-1:0]                 r_waddr, n_waddr;
    logic [lfid_pkg::BIT_IDX_BITS-1:0] r_bit, n_bit;
    lfid_pkg::t_out_item             r_res, n_res;
    logic                            r_out_valid, n_out_valid;
    lfid_pkg::t_out_item             r_out_item, n_out_item;

    logic                            in_acc;
    logic                            cfg_acc;
    logic                            cfg_hit;
    logic [lfid_pkg::ID_BITS-1:0]    lo_c, hi_c;
    logic [RID_WORD_W-1:0]           rid_word;
    logic                            rel_in_range;

    logic [lfid_pkg::WORD_BITS-1:0]  enc_vec;
    lfid_pkg::t_enc_res              enc_res;
    logic [lfid_pkg::WORD_BITS-1:0]  ram_rdata;
    logic [lfid_pkg::WORD_BITS-1:0]  old_word;
    logic [lfid_pkg::WORD_BITS-1:0]  wr_word;
    logic                            ram_wr_en;
    logic                            ram_rd_en;
    logic [WA_W-1:0]                 ram_rd_addr;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

    assign in_acc  = i_in.valid & i_in.ready;
    assign cfg_acc = i_cfg.valid & i_cfg.ready;
    assign cfg_hit = cfg_acc && ((i_cfg.payload.reg_index == lfid_pkg::REG_RANGE_LOW) ||
                                 (i_cfg.payload.reg_index == lfid_pkg::REG_RANGE_HIGH));

    assign rid_word     = i_in.payload.release_id[lfid_pkg::ID_BITS-1:lfid_pkg::BIT_IDX_BITS];
    assign rel_in_range = (i_in.payload.release_id >= r_eff_lo) &&
                          ({1'b0, i_in.payload.release_id} < r_ptr);

    // The summary register is searched while idle, the fetched word afterwards.
    assign enc_vec = (r_state == ST_ALLOC) ? ram_rdata : lfid_pkg::WORD_BITS'(r_summary);

    lfid_prio_enc u_enc (
        .i_vec (enc_vec),
        .o_res (enc_res)
    );

    // A word whose summary bit is clear holds no free ID or has not been written
    // since the last clear, so its RAM contents are treated as all zeros.
    assign old_word = r_summary[r_waddr] ? ram_rdata : '0;

    assign ram_rd_en   = in_acc;
    assign ram_rd_addr = (i_in.payload.action == lfid_pkg::ACT_RELEASE) ?
                         rid_word[WA_W-1:0] : enc_res.idx[WA_W-1:0];

    lfid_ram #(
        .WIDTH (lfid_pkg::WORD_BITS),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_waddr),
        .i_wr_data (wr_word),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        n_range_low  = r_range_low;
        n_range_high = r_range_high;
        if (cfg_acc && (i_cfg.payload.reg_index == lfid_pkg::REG_RANGE_LOW)) begin
            n_range_low = i_cfg.payload.reg_data;
        end
        if (cfg_acc && (i_cfg.payload.reg_index == lfid_pkg::REG_RANGE_HIGH)) begin
            n_range_high = i_cfg.payload.reg_data;
        end
        lo_c = (n_range_low > MAX_ID) ? MAX_ID : n_range_low;
        hi_c = (n_range_high > MAX_ID) ? MAX_ID : n_range_high;
        if (lo_c > hi_c) begin
            n_eff_lo = '0;
            n_eff_hi = MAX_ID;
        end else begin
            n_eff_lo = lo_c;
            n_eff_hi = hi_c;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_summary   = r_summary;
        n_waddr     = r_waddr;
        n_bit       = r_bit;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        ram_wr_en   = 1'b0;
        wr_word     = '0;

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.payload.action == lfid_pkg::ACT_RELEASE) begin
                        n_waddr = rid_word[WA_W-1:0];
                        n_bit   = i_in.payload.release_id[lfid_pkg::BIT_IDX_BITS-1:0];
                        if (rel_in_range) begin
                            n_state = ST_REL;
                        end
                    end else if (enc_res.found) begin
                        n_waddr = enc_res.idx[WA_W-1:0];
                        n_state = ST_ALLOC;
                    end else if (r_ptr <= {1'b0, r_eff_hi}) begin
                        n_res.granted    = 1'b1;
                        n_res.granted_id = r_ptr[lfid_pkg::ID_BITS-1:0];
                        n_ptr            = r_ptr + 1'b1;
                        n_state          = ST_EMIT;
                    end else begin
                        n_res.granted    = 1'b0;
                        n_res.granted_id = '0;
                        n_state          = ST_EMIT;
                    end
                end
            end
            ST_REL: begin
                ram_wr_en = 1'b1;
                wr_word   = old_word | (lfid_pkg::WORD_BITS'(1) << r_bit);
                n_summary[r_waddr] = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_ALLOC: begin
                ram_wr_en = 1'b1;
                wr_word   = ram_rdata & ~(lfid_pkg::WORD_BITS'(1) << enc_res.idx);
                n_summary[r_waddr] = |wr_word;
                n_res.granted    = 1'b1;
                n_res.granted_id = lfid_pkg::ID_BITS'({r_waddr, enc_res.idx});
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cfg_hit) begin
            n_ptr     = {1'b0, n_eff_lo};
            n_summary = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_range_low  <= '0;
            r_range_high <= '1;
            r_eff_lo     <= '0;
            r_eff_hi     <= MAX_ID;
            r_ptr        <= '0;
            r_summary    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_range_low  <= n_range_low;
            r_range_high <= n_range_high;
            if (cfg_hit) begin
                r_eff_lo <= n_eff_lo;
                r_eff_hi <= n_eff_hi;
            end
            r_ptr        <= n_ptr;
            r_summary    <= n_summary;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr    <= n_waddr;
        r_bit      <= n_bit;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

endmodule

// File: rtl/lfid_checker.sv
// ----------------------------------------------------------------------------
// Lowest-free ID allocator checker
// Port-level assertions on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lfid_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_action,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_granted,
    input logic [lfid_pkg::ID_BITS-1:0] i_out_id
);

    // No result beat may be pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat present after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_granted) && $stable(i_out_id)))
        else $error("stalled result beat changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_granted) |-> (i_out_id == '0))
        else $error("failed grant carries a nonzero ID");

    // An allocate keeps the block busy for at least the following cycle.
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_action == lfid_pkg::ACT_ALLOC)) |=> !i_in_ready)
        else $error("request taken right after an allocate");

endmodule

bind lowest_free_id_allocator_core lfid_checker u_lfid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_action   (i_in.payload.action),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_granted (o_out.payload.granted),
    .i_out_id      (o_out.payload.granted_id)
);
